>>> src/tms_pkg.sv
// Package with field widths, command codes and channel payload types for the maximin search.
`default_nettype none
package tms_pkg;

	localparam int ROW_W = 4;
	localparam int COL_W = 5;
	localparam int VAL_W = 16;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [ROW_W-1:0]        row_index;
		logic [COL_W-1:0]        col_index;
		logic signed [VAL_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    read_ok;
		logic [ROW_W-1:0]        best_row;
		logic [COL_W-1:0]        best_col;
	} rsp_t;

endpackage
`default_nettype wire

>>> src/tms_stream_if.sv
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface tms_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/table_maximin_search.sv
// Top level: reading table in a synchronous memory with write, read and maximin search commands.
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+------------------------
//  req     | in  | cmd, row_index, col_index, write_value    | req.valid && req.ready
//  rsp     | out | read_value, read_ok, best_row, best_col   | rsp.valid && rsp.ready
//
// Every command yields exactly one response transfer. A write, an out-of-range read or an
// unused command answers from the idle state; an in-range read waits in the read state for
// the registered table memory output. A search streams all CITIES*HOURS entries through
// the single read port, one per cycle, and answers once the last entry has been read.
// Reset clears the control state only; the table contents are undefined until written.
// A new command is taken only while no command is in flight and the response register is
// empty or being emptied in the same cycle, so a stalled rsp side holds off req.
`default_nettype none
module table_maximin_search #(
	parameter int CITIES = 10,
	parameter int HOURS  = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	tms_stream_if.sink   req,
	tms_stream_if.source rsp
);

	localparam int DEPTH = CITIES * HOURS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Table memory, row-major: address = row * HOURS + col.
	logic signed [tms_pkg::VAL_W-1:0] mem [DEPTH];
	logic signed [tms_pkg::VAL_W-1:0] rd_data_q;

	logic            rsp_valid_q;
	tms_pkg::rsp_t   rsp_q;
	logic            rsp_load;
	tms_pkg::rsp_t   rsp_n;

	// Scan address generation.
	logic [AW-1:0]             scan_addr_q;
	logic [tms_pkg::ROW_W-1:0] scan_row_q;
	logic [tms_pkg::COL_W-1:0] scan_col_q;
	logic                      scan_last;

	// Tags that travel alongside the memory read data.
	logic                      scan_vld_s1;
	logic [tms_pkg::ROW_W-1:0] row_s1;
	logic [tms_pkg::COL_W-1:0] col_s1;

	// Running row minimum and best of the row minima.
	logic signed [tms_pkg::VAL_W-1:0] min_val_q;
	logic [tms_pkg::COL_W-1:0]        min_col_q;
	logic signed [tms_pkg::VAL_W-1:0] best_val_q;
	logic [tms_pkg::ROW_W-1:0]        best_row_q;
	logic [tms_pkg::COL_W-1:0]        best_col_q;

	logic                             req_fire;
	logic                             in_range;
	logic [AW-1:0]                    req_addr;
	logic [AW-1:0]                    rd_addr;
	logic signed [tms_pkg::VAL_W-1:0] cand_val;
	logic [tms_pkg::COL_W-1:0]        cand_col;
	logic                             row_end_s1;
	logic                             best_upd;
	logic [tms_pkg::ROW_W-1:0]        best_row_n;
	logic [tms_pkg::COL_W-1:0]        best_col_n;

	assign req.ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire    = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign in_range = (32'(req.payload.row_index) < CITIES) &&
	                  (32'(req.payload.col_index) < HOURS);
	assign req_addr = AW'(32'(req.payload.row_index) * HOURS + 32'(req.payload.col_index));

	// The read port serves the scan address while scanning and the request address otherwise.
	assign rd_addr = (state_q == ST_SCAN) ? scan_addr_q : req_addr;

	assign scan_last = (scan_row_q == tms_pkg::ROW_W'(CITIES - 1)) &&
	                   (scan_col_q == tms_pkg::COL_W'(HOURS - 1));

	always_ff @(posedge clk) begin
		if (req_fire && (req.payload.cmd == tms_pkg::CMD_WRITE) && in_range) begin
			mem[req_addr] <= req.payload.write_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	// The first column of a row starts a fresh minimum; a strict compare keeps the first
	// column on ties. Likewise the first row starts a fresh best, and later rows must be
	// strictly larger to take over.
	always_comb begin
		if ((col_s1 == '0) || (rd_data_q < min_val_q)) begin
			cand_val = rd_data_q;
			cand_col = col_s1;
		end else begin
			cand_val = min_val_q;
			cand_col = min_col_q;
		end
		row_end_s1 = (col_s1 == tms_pkg::COL_W'(HOURS - 1));
		best_upd   = scan_vld_s1 && row_end_s1 && ((row_s1 == '0) || (cand_val > best_val_q));
		best_row_n = best_upd ? row_s1   : best_row_q;
		best_col_n = best_upd ? cand_col : best_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= scan_row_q;
		col_s1 <= scan_col_q;
		if (state_q == ST_SCAN) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			if (scan_col_q == tms_pkg::COL_W'(HOURS - 1)) begin
				scan_col_q <= '0;
				scan_row_q <= scan_row_q + tms_pkg::ROW_W'(1);
			end else begin
				scan_col_q <= scan_col_q + tms_pkg::COL_W'(1);
			end
		end else begin
			scan_addr_q <= '0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
		end
		if (scan_vld_s1) begin
			min_val_q <= cand_val;
			min_col_q <= cand_col;
			if (best_upd) begin
				best_val_q <= cand_val;
				best_row_q <= row_s1;
				best_col_q <= cand_col;
			end
		end
	end

	// Response to load this cycle. The response register is always free when one is loaded:
	// an idle transfer needs it empty or emptying, and reads and searches block new commands.
	always_comb begin
		rsp_load = 1'b0;
		rsp_n    = '0;
		unique case (state_q)
			ST_IDLE: begin
				// Writes, out-of-range reads and the unused code answer at once with all
				// fields zero.
				rsp_load = req_fire && (req.payload.cmd != tms_pkg::CMD_SEARCH) &&
				           !((req.payload.cmd == tms_pkg::CMD_READ) && in_range);
			end
			ST_READ: begin
				rsp_load         = 1'b1;
				rsp_n.read_value = rd_data_q;
				rsp_n.read_ok    = 1'b1;
			end
			ST_FINISH: begin
				// The last entry of the table is in the read register this cycle.
				rsp_load       = 1'b1;
				rsp_n.best_row = best_row_n;
				rsp_n.best_col = best_col_n;
			end
			default: begin
			end
		endcase
	end

	// Command sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_n;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if ((req.payload.cmd == tms_pkg::CMD_READ) && in_range) begin
							state_q <= ST_READ;
						end else if (req.payload.cmd == tms_pkg::CMD_SEARCH) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
